// ===== hdl/arq_pkg.sv =====
package arq_pkg;

    typedef enum logic [2:0] {
        KIND_SCHEDULED = 3'd0,
        KIND_TABLE_FULL = 3'd1,
        KIND_ACK_MATCHED = 3'd2,
        KIND_FIRST_SEND = 3'd3,
        KIND_RETRY_SEND = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        FUNC_SCHEDULE = 2'd0,
        FUNC_ACK = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_ACK_TIMEOUT = 3'd0,
        REG_MAX_RETRIES = 3'd1,
        REG_BACKOFF_INIT = 3'd2,
        REG_BACKOFF_MAX = 3'd3,
        REG_EPOCH = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_PLACE,
        ST_RTT,
        ST_DONE
    } state_t;

    // Table and peer sizes are tied to the widths of the slot and peer ports.
    localparam int TABLE_SLOTS = 16;
    localparam int PEER_SLOTS = 8;

    localparam int TIME_W = 48;
    localparam int RTT_W = 28;
    localparam int SEQ_W = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [RTT_W-1:0] RTT_MAX = {RTT_W{1'b1}};

endpackage

// ===== hdl/arq_retransmit_timer_unit.sv =====
// ARQ retransmission timer. Each command (schedule, ack or tick) is taken at
// a rising edge at which start is high and busy is low, and then walks the
// pending table one entry per cycle through a single table read port. busy
// stays high until the sequencer is back in idle: on a schedule or a matched
// ack it issues the first read, walks the table, closes the walk, places or
// frees the entry and presents the final word; on a tick or an unmatched ack
// it closes the walk and then presents any final word, and on the unused
// function code it skips the walk. The next command is taken at the end of
// the first cycle in which busy is low. Results appear on the result ports
// for one cycle each, marked by strobe; the receiver cannot stall them, and
// the word carrying last closes the command. A schedule gives exactly one
// word, a matching ack one word, an unmatched ack none, and a tick one word
// for every entry that fell due. Every word appears while busy is high.
module arq_retransmit_timer_unit #(
    parameter int MAX_SHIFT = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [2:0]  peer,
    input  logic [31:0] msg_id,
    input  logic [47:0] now_ms,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        strobe,
    output logic [2:0]  kind,
    output logic [3:0]  slot,
    output logic [2:0]  peer_out,
    output logic [31:0] id_out,
    output logic [7:0]  tries_out,
    output logic        dropped,
    output logic        last
);
    localparam int TABLE_SLOTS = arq_pkg::TABLE_SLOTS;
    localparam int PEER_SLOTS = arq_pkg::PEER_SLOTS;
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int SH_W = $clog2(MAX_SHIFT + 1) + 1;

    // Configuration registers.
    logic [15:0] ack_to_reg, binit_reg, bmax_reg;
    logic [7:0]  maxr_reg;
    logic [11:0] epoch_reg;
    logic [19:0] seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_to_reg <= 16'd500;
            maxr_reg <= 8'd5;
            binit_reg <= 16'd200;
            bmax_reg <= 16'd2000;
            epoch_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                arq_pkg::REG_ACK_TIMEOUT:  ack_to_reg <= cfg_data;
                arq_pkg::REG_MAX_RETRIES:  maxr_reg <= cfg_data[7:0];
                arq_pkg::REG_BACKOFF_INIT: binit_reg <= cfg_data;
                arq_pkg::REG_BACKOFF_MAX:  bmax_reg <= cfg_data;
                arq_pkg::REG_EPOCH:        epoch_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Captured command.
    logic [1:0]  cmd_func_reg;
    logic [2:0]  cmd_peer_reg;
    logic [31:0] cmd_id_reg;
    logic [47:0] now_reg;

    // Pending table: valid bits in flops, the payload in a memory with one
    // read port (registered) and one write port.
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [2:0]  mem_peer [TABLE_SLOTS];
    logic [31:0] mem_id [TABLE_SLOTS];
    logic [7:0]  mem_tries [TABLE_SLOTS];
    logic [47:0] mem_due [TABLE_SLOTS];
    logic [47:0] mem_first [TABLE_SLOTS];
    logic [2:0]  rd_peer;
    logic [31:0] rd_id;
    logic [7:0]  rd_tries;
    logic [47:0] rd_due, rd_first;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic        wr_full, wr_tries;
    logic [7:0]  wr_tries_val;
    logic [47:0] wr_due_val;

    always_ff @(posedge clk)
    begin
        rd_peer <= mem_peer[rd_addr];
        rd_id <= mem_id[rd_addr];
        rd_tries <= mem_tries[rd_addr];
        rd_due <= mem_due[rd_addr];
        rd_first <= mem_first[rd_addr];
        if (wr_full)
        begin
            mem_peer[wr_addr] <= cmd_peer_reg;
            mem_id[wr_addr] <= cmd_id_reg;
            mem_tries[wr_addr] <= '0;
            mem_due[wr_addr] <= now_reg;
            mem_first[wr_addr] <= now_reg;
        end
        else if (wr_tries)
        begin
            mem_tries[wr_addr] <= wr_tries_val;
            mem_due[wr_addr] <= wr_due_val;
        end
    end

    // Sequencer.
    arq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg;          // address issued to the read port
    logic [IDX_W-1:0] cur_reg;          // entry whose data is on rd_*
    logic        cur_ok_reg;
    logic        match_reg, free_reg;
    logic [IDX_W-1:0] match_idx_reg, free_idx_reg;
    logic        pend_reg;              // a tick word is held back for 'last'
    logic        out_v_reg;

    // Word held back one entry so that 'last' can be set on the final one.
    logic [2:0]  h_kind_reg, h_peer_reg;
    logic [IDX_W-1:0] h_slot_reg;
    logic [31:0] h_id_reg;
    logic [7:0]  h_tries_reg;
    logic        h_drop_reg, h_last_reg;

    logic        hit;
    logic [15:0] first_to;
    logic        rtt_upd;

    // The RTT lookup needs the peer of the current entry; on a matched ack
    // the matched entry's peer is the command's peer.
    logic [2:0] rtt_peer;
    assign rtt_peer = rd_peer;

    assign hit = valid_reg[cur_reg] && rd_peer == cmd_peer_reg && rd_id == cmd_id_reg;
    // While the walk closes on an ack, the matched entry is read back so that
    // its data is on rd_* during the RTT update.
    assign rd_addr = (state_reg == arq_pkg::ST_RTT
                      || (state_reg == arq_pkg::ST_SCAN && !cur_ok_reg
                          && cmd_func_reg == arq_pkg::FUNC_ACK))
                   ? match_idx_reg : idx_reg[IDX_W-1:0];
    assign rtt_upd = (state_reg == arq_pkg::ST_RTT);

    arq_rtt #(.PEER_SLOTS(PEER_SLOTS), .PEER_W(3)) u_rtt (
        .clk(clk), .rst_n(rst_n), .upd(rtt_upd), .peer(rtt_peer),
        .sample((now_reg >= rd_first) ? now_reg - rd_first : 48'd0),
        .ack_timeout(ack_to_reg), .backoff_max(bmax_reg),
        .first_to(first_to)
    );

    // Tick arithmetic for the entry on the read port.
    logic [7:0]  t_new;
    logic [SH_W-1:0] sh;
    logic [15+MAX_SHIFT:0] boff;
    logic [15:0] wait_ms;
    logic [48:0] due_sum;
    logic        is_due, drop;

    always_comb
    begin
        t_new = (rd_tries == 8'hFF) ? rd_tries : rd_tries + 8'd1;
        sh = ((t_new - 8'd1) > 8'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT) : SH_W'(t_new - 8'd1);
        boff = (16+MAX_SHIFT)'(binit_reg) << sh;
        wait_ms = (t_new == 8'd1) ? first_to
                : ((boff > (16+MAX_SHIFT)'(bmax_reg)) ? bmax_reg : boff[15:0]);
        due_sum = {1'b0, now_reg} + 49'(wait_ms);
        is_due = valid_reg[cur_reg] && rd_due <= now_reg;
        drop = maxr_reg != 8'd0 && t_new > maxr_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arq_pkg::ST_IDLE:  if (start) state_next = arq_pkg::ST_READ;
            arq_pkg::ST_READ:  state_next = (cmd_func_reg == arq_pkg::FUNC_NONE)
                                          ? arq_pkg::ST_DONE : arq_pkg::ST_SCAN;
            arq_pkg::ST_SCAN:
                if (!cur_ok_reg)
                    state_next = (cmd_func_reg == arq_pkg::FUNC_SCHEDULE) ? arq_pkg::ST_PLACE
                               : (cmd_func_reg == arq_pkg::FUNC_ACK && match_reg)
                               ? arq_pkg::ST_RTT : arq_pkg::ST_DONE;
            arq_pkg::ST_PLACE: state_next = arq_pkg::ST_DONE;
            arq_pkg::ST_RTT:   state_next = arq_pkg::ST_DONE;
            arq_pkg::ST_DONE:  state_next = arq_pkg::ST_IDLE;
            default:           state_next = arq_pkg::ST_IDLE;
        endcase
    end

    assign busy = (state_reg != arq_pkg::ST_IDLE);

    always_comb
    begin
        wr_full = 1'b0;
        wr_tries = 1'b0;
        wr_addr = cur_reg;
        wr_tries_val = t_new;
        wr_due_val = due_sum[48] ? arq_pkg::TIME_MAX : due_sum[47:0];
        if (state_reg == arq_pkg::ST_PLACE && (match_reg || free_reg))
        begin
            wr_full = 1'b1;
            wr_addr = match_reg ? match_idx_reg : free_idx_reg;
        end
        else if (state_reg == arq_pkg::ST_SCAN && cur_ok_reg
                 && cmd_func_reg == arq_pkg::FUNC_TICK && is_due)
        begin
            wr_tries = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arq_pkg::ST_IDLE;
            valid_reg <= '0;
            seq_reg <= '0;
            idx_reg <= '0;
            cur_ok_reg <= 1'b0;
            match_reg <= 1'b0;
            free_reg <= 1'b0;
            pend_reg <= 1'b0;
            out_v_reg <= 1'b0;
            h_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= 1'b0;
            h_last_reg <= 1'b0;
            unique case (state_reg)
                arq_pkg::ST_IDLE:
                begin
                    idx_reg <= '0;
                    match_reg <= 1'b0;
                    free_reg <= 1'b0;
                    pend_reg <= 1'b0;
                    cur_ok_reg <= 1'b0;
                    if (start && func == arq_pkg::FUNC_SCHEDULE && msg_id == 32'd0)
                        seq_reg <= seq_reg + 20'd1;
                end
                arq_pkg::ST_READ:
                begin
                    cur_reg <= idx_reg[IDX_W-1:0];
                    cur_ok_reg <= 1'b1;
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                arq_pkg::ST_SCAN:
                begin
                    if (cur_ok_reg)
                    begin
                        if (cmd_func_reg == arq_pkg::FUNC_TICK)
                        begin
                            if (is_due)
                            begin
                                if (pend_reg)
                                    out_v_reg <= 1'b1;
                                pend_reg <= 1'b1;
                                h_kind_reg <= (t_new == 8'd1) ? arq_pkg::KIND_FIRST_SEND
                                                              : arq_pkg::KIND_RETRY_SEND;
                                h_slot_reg <= cur_reg;
                                h_peer_reg <= rd_peer;
                                h_id_reg <= rd_id;
                                h_tries_reg <= t_new;
                                h_drop_reg <= drop;
                                if (drop)
                                    valid_reg[cur_reg] <= 1'b0;
                            end
                        end
                        else
                        begin
                            if (hit && !match_reg)
                            begin
                                match_reg <= 1'b1;
                                match_idx_reg <= cur_reg;
                            end
                            if (!valid_reg[cur_reg] && !free_reg)
                            begin
                                free_reg <= 1'b1;
                                free_idx_reg <= cur_reg;
                            end
                        end
                        cur_reg <= idx_reg[IDX_W-1:0];
                        cur_ok_reg <= (idx_reg < CNT_W'(TABLE_SLOTS));
                        if (idx_reg < CNT_W'(TABLE_SLOTS))
                            idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else if (cmd_func_reg == arq_pkg::FUNC_TICK && pend_reg)
                    begin
                        out_v_reg <= 1'b1;
                        h_last_reg <= 1'b1;
                        pend_reg <= 1'b0;
                    end
                end
                arq_pkg::ST_PLACE:
                begin
                    out_v_reg <= 1'b1;
                    h_last_reg <= 1'b1;
                    h_peer_reg <= cmd_peer_reg;
                    h_id_reg <= cmd_id_reg;
                    h_tries_reg <= '0;
                    h_drop_reg <= 1'b0;
                    if (match_reg || free_reg)
                    begin
                        h_kind_reg <= arq_pkg::KIND_SCHEDULED;
                        h_slot_reg <= match_reg ? match_idx_reg : free_idx_reg;
                        valid_reg[match_reg ? match_idx_reg : free_idx_reg] <= 1'b1;
                    end
                    else
                    begin
                        h_kind_reg <= arq_pkg::KIND_TABLE_FULL;
                        h_slot_reg <= '0;
                    end
                end
                arq_pkg::ST_RTT:
                begin
                    // rd_* now holds the matched entry.
                    out_v_reg <= 1'b1;
                    h_last_reg <= 1'b1;
                    h_kind_reg <= arq_pkg::KIND_ACK_MATCHED;
                    h_slot_reg <= match_idx_reg;
                    h_peer_reg <= cmd_peer_reg;
                    h_id_reg <= cmd_id_reg;
                    h_tries_reg <= rd_tries;
                    h_drop_reg <= 1'b0;
                    valid_reg[match_idx_reg] <= 1'b0;
                end
                arq_pkg::ST_DONE: ;
                default: ;
            endcase
        end
    end

    // The held tick word goes out in the cycle after it is replaced, so it
    // is copied into the output register while the holding one moves on.
    logic [2:0]  o_kind_reg, o_peer_reg;
    logic [IDX_W-1:0] o_slot_reg;
    logic [31:0] o_id_reg;
    logic [7:0]  o_tries_reg;
    logic        o_drop_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == arq_pkg::ST_SCAN && cur_ok_reg)
        begin
            o_kind_reg <= h_kind_reg;
            o_slot_reg <= h_slot_reg;
            o_peer_reg <= h_peer_reg;
            o_id_reg <= h_id_reg;
            o_tries_reg <= h_tries_reg;
            o_drop_reg <= h_drop_reg;
        end
    end

    logic use_h;
    assign use_h = h_last_reg;

    assign strobe = out_v_reg;
    assign kind = use_h ? h_kind_reg : o_kind_reg;
    assign slot = 4'(use_h ? h_slot_reg : o_slot_reg);
    assign peer_out = use_h ? h_peer_reg : o_peer_reg;
    assign id_out = use_h ? h_id_reg : o_id_reg;
    assign tries_out = use_h ? h_tries_reg : o_tries_reg;
    assign dropped = use_h ? h_drop_reg : o_drop_reg;
    assign last = h_last_reg;

    // Capture of the command.
    always_ff @(posedge clk)
    begin
        if (state_reg == arq_pkg::ST_IDLE && start)
        begin
            cmd_func_reg <= func;
            cmd_peer_reg <= peer;
            now_reg <= now_ms;
            cmd_id_reg <= (func == arq_pkg::FUNC_SCHEDULE && msg_id == 32'd0)
                        ? {epoch_reg, seq_reg} : msg_id;
        end
    end
endmodule

// ===== hdl/arq_rtt.sv =====
// Per-peer RTT estimator. One update or one timeout lookup per request;
// the update is registered, and its arithmetic multiplies only by constants.
module arq_rtt #(
    parameter int PEER_SLOTS = 8,
    parameter int PEER_W = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          upd,
    input  logic [PEER_W-1:0]             peer,
    input  logic [arq_pkg::TIME_W-1:0]    sample,
    input  logic [15:0]                   ack_timeout,
    input  logic [15:0]                   backoff_max,
    output logic [15:0]                   first_to
);
    localparam int PIDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

    logic [arq_pkg::RTT_W-1:0] srtt_reg [PEER_SLOTS];
    logic [arq_pkg::RTT_W-1:0] var_reg [PEER_SLOTS];
    logic                      in_range;
    logic [arq_pkg::RTT_W-1:0] s8, srtt, var_c, diff, varm;
    logic [arq_pkg::RTT_W+2:0] dyn, sum7, sum3;
    logic [15:0]               dyn16;
    logic [PIDX_W-1:0]         pidx;

    assign in_range = ({1'b0, peer} < (PEER_W+1)'(PEER_SLOTS));
    assign pidx = in_range ? PIDX_W'(peer) : '0;
    assign srtt = srtt_reg[pidx];
    assign var_c = var_reg[pidx];
    assign s8 = (sample > arq_pkg::TIME_W'(arq_pkg::RTT_MAX >> 3)) ? arq_pkg::RTT_MAX
              : arq_pkg::RTT_W'(sample << 3);
    assign diff = (srtt >= s8) ? srtt - s8 : s8 - srtt;
    assign sum3 = 31'(var_c) * 31'd3 + 31'(diff);
    assign sum7 = 31'(srtt) * 31'd7 + 31'(s8);
    assign varm = (var_c < 28'd8) ? 28'd8 : var_c;
    assign dyn = (31'(srtt) + {1'b0, varm, 2'b00}) >> 3;
    assign dyn16 = (dyn > 31'(backoff_max)) ? backoff_max : dyn[15:0];

    always_comb
    begin
        first_to = ack_timeout;
        if (in_range && srtt > 28'd8 && dyn16 > ack_timeout)
        begin
            first_to = dyn16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PEER_SLOTS; i++)
            begin
                srtt_reg[i] <= '0;
                var_reg[i] <= '0;
            end
        end
        else if (upd && in_range)
        begin
            if (srtt == '0)
            begin
                srtt_reg[pidx] <= s8;
                var_reg[pidx] <= s8 >> 1;
            end
            else
            begin
                var_reg[pidx] <= sum3[arq_pkg::RTT_W+1:2];
                srtt_reg[pidx] <= sum7[arq_pkg::RTT_W+2:3];
            end
        end
    end
endmodule

// ===== hdl/arq_checker.sv =====
module arq_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input logic last,
    input logic [2:0] kind,
    input logic dropped
);
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy) else $error("word outside a command");
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe) else $error("last without a word");
    a_drop_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && dropped) |-> (kind == arq_pkg::KIND_FIRST_SEND
                                 || kind == arq_pkg::KIND_RETRY_SEND))
        else $error("drop on a non-send word");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("command not taken");
endmodule

bind arq_retransmit_timer_unit arq_checker u_arq_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .strobe(strobe),
    .last(last), .kind(kind), .dropped(dropped)
);

// ===== test/arq_retransmit_timer_unit_test.sv =====
// Self-checking testbench for the ARQ retransmission timer.
// A behavioural copy of the timer lives in a small scoreboard class: every
// accepted command is fed to it, and it queues the words that the block should
// produce. Each strobed result word is then checked against the oldest queued
// word. Commands are driven at the falling edge and results sampled at the
// rising edge, so nothing depends on event order within a time step.
module arq_retransmit_timer_unit_test;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [2:0]  peer;
        logic [31:0] id;
        logic [7:0]  tries;
        logic        dropped;
        logic        last;
    } timer_word_t;

    // Behavioural timer plus the queue of words it says the block will send.
    class timer_scoreboard;
        logic [15:0] ack_timeout;
        logic [7:0]  retry_limit;
        logic [15:0] backoff_base;
        logic [15:0] backoff_cap;
        logic [11:0] epoch;
        bit          used [16];
        logic [2:0]  owner [16];
        logic [31:0] ident [16];
        logic [7:0]  sends [16];
        logic [47:0] due_at [16];
        logic [47:0] sent_at [16];
        logic [27:0] srtt [8];
        logic [27:0] rttvar [8];
        logic [19:0] seq;
        timer_word_t pending_words [$];
        int          mismatches;

        function new();
            ack_timeout = 16'd500;
            retry_limit = 8'd5;
            backoff_base = 16'd200;
            backoff_cap = 16'd2000;
            epoch = 12'd0;
            seq = 20'd0;
            mismatches = 0;
            for (int i = 0; i < 16; i++) used[i] = 1'b0;
            for (int p = 0; p < 8; p++)
            begin
                srtt[p] = 28'd0;
                rttvar[p] = 28'd0;
            end
        endfunction

        function void write_reg(arq_pkg::reg_index_t idx, logic [15:0] v);
            case (idx)
                arq_pkg::REG_ACK_TIMEOUT: ack_timeout = v;
                arq_pkg::REG_MAX_RETRIES: retry_limit = v[7:0];
                arq_pkg::REG_BACKOFF_INIT: backoff_base = v;
                arq_pkg::REG_BACKOFF_MAX: backoff_cap = v;
                arq_pkg::REG_EPOCH: epoch = v[11:0];
                default: ;
            endcase
        endfunction

        function automatic logic [63:0] first_wait(logic [2:0] p);
            logic [63:0] v, dyn;
            if (srtt[p] <= 8) return 64'(ack_timeout);
            v = (rttvar[p] < 8) ? 64'd8 : 64'(rttvar[p]);
            dyn = (64'(srtt[p]) + 4 * v) >> 3;
            if (dyn > 64'(backoff_cap)) dyn = 64'(backoff_cap);
            return (dyn > 64'(ack_timeout)) ? dyn : 64'(ack_timeout);
        endfunction

        function automatic logic [63:0] retry_wait(logic [7:0] t);
            int sh;
            logic [63:0] b;
            sh = t - 1;
            if (sh > 10) sh = 10;
            b = 64'(backoff_base) << sh;
            return (b > 64'(backoff_cap)) ? 64'(backoff_cap) : b;
        endfunction

        function void push(logic [2:0] k, int s, logic [2:0] p, logic [31:0] id,
                           logic [7:0] t, logic d);
            timer_word_t w;
            w.kind = k;
            w.slot = s[3:0];
            w.peer = p;
            w.id = id;
            w.tries = t;
            w.dropped = d;
            w.last = 1'b0;
            pending_words.insert(pending_words.size(), w);
        endfunction

        // Notes an accepted command and queues the words it should cause.
        function void note_command(arq_pkg::func_t f, logic [2:0] p, logic [31:0] id,
                                   logic [47:0] now);
            int hit, n0;
            logic [63:0] sample, s8, diff, w, sum;
            logic [7:0]  t;
            logic        d;
            hit = -1;
            n0 = pending_words.size();
            if (f == arq_pkg::FUNC_SCHEDULE)
            begin
                if (id == 0)
                begin
                    id = {epoch, seq};
                    seq = seq + 20'd1;
                end
                for (int i = 0; i < 16 && hit < 0; i++)
                    if (used[i] && owner[i] == p && ident[i] == id) hit = i;
                for (int i = 0; i < 16 && hit < 0; i++)
                    if (!used[i]) hit = i;
                if (hit < 0) push(arq_pkg::KIND_TABLE_FULL, 0, p, id, 8'd0, 1'b0);
                else
                begin
                    used[hit] = 1'b1;
                    owner[hit] = p;
                    ident[hit] = id;
                    sends[hit] = 8'd0;
                    due_at[hit] = now;
                    sent_at[hit] = now;
                    push(arq_pkg::KIND_SCHEDULED, hit, p, id, 8'd0, 1'b0);
                end
            end
            else if (f == arq_pkg::FUNC_ACK)
            begin
                for (int i = 0; i < 16 && hit < 0; i++)
                    if (used[i] && owner[i] == p && ident[i] == id) hit = i;
                if (hit >= 0)
                begin
                    sample = (now >= sent_at[hit]) ? 64'(now - sent_at[hit]) : 64'd0;
                    s8 = sample << 3;
                    if (s8 > 64'hFFFFFFF) s8 = 64'hFFFFFFF;
                    if (srtt[p] == 0)
                    begin
                        srtt[p] = s8[27:0];
                        rttvar[p] = s8[28:1];
                    end
                    else
                    begin
                        diff = (64'(srtt[p]) >= s8) ? 64'(srtt[p]) - s8 : s8 - 64'(srtt[p]);
                        rttvar[p] = 28'((3 * 64'(rttvar[p]) + diff) >> 2);
                        srtt[p] = 28'((7 * 64'(srtt[p]) + s8) >> 3);
                    end
                    used[hit] = 1'b0;
                    push(arq_pkg::KIND_ACK_MATCHED, hit, p, id, sends[hit], 1'b0);
                end
            end
            else if (f == arq_pkg::FUNC_TICK)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (!used[i] || due_at[i] > now) continue;
                    w = first_wait(owner[i]);
                    t = sends[i];
                    if (t < 255) t = t + 8'd1;
                    sends[i] = t;
                    if (t != 1) w = retry_wait(t);
                    sum = 64'(now) + w;
                    due_at[i] = (sum > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : sum[47:0];
                    d = (retry_limit > 0 && t > retry_limit);
                    push((t == 1) ? arq_pkg::KIND_FIRST_SEND : arq_pkg::KIND_RETRY_SEND,
                         i, owner[i], ident[i], t, d);
                    if (d) used[i] = 1'b0;
                end
            end
            if (pending_words.size() > n0)
                pending_words[pending_words.size() - 1].last = 1'b1;
        endfunction

        // Checks one result word against the oldest expectation.
        function void check_word(timer_word_t got);
            timer_word_t want;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", got);
                return;
            end
            want = pending_words.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  func = 0;
    logic [2:0]  peer = 0;
    logic [31:0] msg_id = 0;
    logic [47:0] now_ms = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic        strobe;
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [2:0]  peer_out;
    logic [31:0] id_out;
    logic [7:0]  tries_out;
    logic        dropped;
    logic        last;

    timer_scoreboard board = new();
    int          gap_pct;
    logic [47:0] clock_ms;
    logic [31:0] recent_ids [$];

    always #5 clk = ~clk;

    arq_retransmit_timer_unit u_dut (.*);

    // Result words are sampled at the rising edge that closes their cycle.
    always @(posedge clk)
        if (rst_n && strobe)
            board.check_word({kind, slot, peer_out, id_out, tries_out, dropped, last});

    // Register writes happen only while the block is idle and nothing is owed.
    task automatic write_reg(arq_pkg::reg_index_t idx, logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, v);
    endtask

    task automatic drain();
        while (board.pending_words.size() != 0) @(posedge clk);
        // An unmatched ack leaves the walk running with nothing owed.
        repeat (30) @(posedge clk);
    endtask

    // Offers one command word, with an occasional idle gap beforehand.
    task automatic send_command(arq_pkg::func_t f, logic [2:0] p, logic [31:0] id,
                                logic [47:0] now);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct) @(negedge clk);
        start <= 1'b1;
        func <= f;
        peer <= p;
        msg_id <= id;
        now_ms <= now;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_command(f, p, id, now);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic random_command();
        int          r;
        logic [31:0] id;
        logic [2:0]  p;
        r = $urandom_range(99);
        p = 3'($urandom_range(7));
        if ($urandom_range(9) < 8) clock_ms = clock_ms + 48'($urandom_range(600));
        else clock_ms = 48'({$urandom, $urandom});
        if (r < 35)
        begin
            id = ($urandom_range(3) == 0) ? 32'd0 : {$urandom_range(15) == 0 ?
                 $urandom : 32'($urandom_range(20))};
            if (id != 0) recent_ids.insert(recent_ids.size(), id);
            if (recent_ids.size() > 12) void'(recent_ids.pop_front());
            send_command(arq_pkg::FUNC_SCHEDULE, p, id, clock_ms);
        end
        else if (r < 60)
        begin
            id = (recent_ids.size() != 0 && $urandom_range(3) != 0) ?
                 recent_ids[$urandom_range(recent_ids.size() - 1)] : $urandom;
            send_command(arq_pkg::FUNC_ACK, p, id, clock_ms);
        end
        else if (r < 97) send_command(arq_pkg::FUNC_TICK, p, $urandom, clock_ms);
        else send_command(arq_pkg::FUNC_NONE, p, $urandom, clock_ms);
    endtask

    initial
    begin
        gap_pct = 8;
        clock_ms = 48'd1000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes of ids, times and peers, ack miss and match,
        // overwrite of a live entry, a full table, and the unused function.
        send_command(arq_pkg::FUNC_SCHEDULE, 3'd0, 32'd0, 48'd0);
        send_command(arq_pkg::FUNC_SCHEDULE, 3'd7, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF);
        send_command(arq_pkg::FUNC_SCHEDULE, 3'd7, 32'hFFFFFFFF, 48'd10);
        send_command(arq_pkg::FUNC_TICK, 3'd3, 32'd0, 48'd10);
        send_command(arq_pkg::FUNC_ACK, 3'd7, 32'hFFFFFFFE, 48'd20);
        send_command(arq_pkg::FUNC_ACK, 3'd7, 32'hFFFFFFFF, 48'd5);
        send_command(arq_pkg::FUNC_ACK, 3'd0, 32'd0, 48'hFFFFFFFFFFFF);
        send_command(arq_pkg::FUNC_NONE, 3'd5, 32'd1, 48'd100);
        for (int i = 0; i < 17; i++)
            send_command(arq_pkg::FUNC_SCHEDULE, 3'(i), 32'd0, 48'hFFFFFFFFFFF0);
        send_command(arq_pkg::FUNC_TICK, 3'd0, 32'd0, 48'hFFFFFFFFFFFF);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            gap_pct = (ph < 2) ? 8 : (ph < 4) ? 71 : 0;
            case (ph)
                0:
                begin
                    write_reg(arq_pkg::REG_ACK_TIMEOUT, 16'd0);
                    write_reg(arq_pkg::REG_MAX_RETRIES, 16'd0);
                    write_reg(arq_pkg::REG_BACKOFF_INIT, 16'd0);
                    write_reg(arq_pkg::REG_BACKOFF_MAX, 16'd0);
                    write_reg(arq_pkg::REG_EPOCH, 16'hFFF);
                end
                1:
                begin
                    write_reg(arq_pkg::REG_ACK_TIMEOUT, 16'hFFFF);
                    write_reg(arq_pkg::REG_MAX_RETRIES, 16'd255);
                    write_reg(arq_pkg::REG_BACKOFF_INIT, 16'hFFFF);
                    write_reg(arq_pkg::REG_BACKOFF_MAX, 16'hFFFF);
                    write_reg(arq_pkg::REG_EPOCH, 16'd0);
                end
                default:
                begin
                    write_reg(arq_pkg::REG_ACK_TIMEOUT, 16'($urandom_range(800)));
                    write_reg(arq_pkg::REG_MAX_RETRIES, 16'($urandom_range(6)));
                    write_reg(arq_pkg::REG_BACKOFF_INIT, 16'($urandom_range(1, 300)));
                    write_reg(arq_pkg::REG_BACKOFF_MAX, 16'($urandom_range(3000)));
                    write_reg(arq_pkg::REG_EPOCH, 16'($urandom));
                end
            endcase
            for (int n = 0; n < 56; n++) random_command();
            drain();
        end

        if (board.mismatches == 0 && board.pending_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
